// File: rtl/core/csco_pkg.sv
// ----------------------------------------------------------------------------
// csco_pkg
// Shared types and constants of the core spread CPU order block.
// ----------------------------------------------------------------------------
`default_nettype none

package csco_pkg;

	localparam int MAX_CPUS  = 64;
	localparam int MAX_CORES = 64;

	localparam int SLOT_W = 6;
	localparam int CORE_W = 6;
	localparam int ADDR_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int CNT_W  = ADDR_W + 1;

	localparam logic [CORE_W-1:0] CORE_TOP = CORE_W'(MAX_CORES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
		logic present;
		logic first;
	} scan_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/csco_ram.sv
// ----------------------------------------------------------------------------
// csco_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                          wr_data,
	input  wire logic                                      rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/csco_scan.sv
// ----------------------------------------------------------------------------
// csco_scan
// Compare unit that walks the table one entry per cycle and keeps the best
// entry above the floor and the best entry overall.
// ----------------------------------------------------------------------------
`default_nettype none

module csco_scan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire csco_pkg::scan_ctl_t             ctl,
	input  wire logic [csco_pkg::ADDR_W-1:0]     idx,
	input  wire logic [csco_pkg::CORE_W-1:0]     core,
	input  wire logic [csco_pkg::CORE_W-1:0]     floor_core,
	output logic                                 found,
	output logic      [csco_pkg::ADDR_W-1:0]     pick_idx,
	output logic      [csco_pkg::CORE_W-1:0]     pick_core
);

	logic                        ab_found_q;
	logic [csco_pkg::ADDR_W-1:0] ab_idx_q;
	logic [csco_pkg::CORE_W-1:0] ab_core_q;
	logic                        al_found_q;
	logic [csco_pkg::ADDR_W-1:0] al_idx_q;
	logic [csco_pkg::CORE_W-1:0] al_core_q;
	logic                        take_ab;
	logic                        take_al;

	always_comb begin
		take_ab = ctl.valid && ctl.present && (ctl.first || (core > floor_core))
			&& (!ab_found_q || (core < ab_core_q));
		take_al = ctl.valid && ctl.present && (!al_found_q || (core < al_core_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_found_q <= 1'b0;
			al_found_q <= 1'b0;
		end else if (ctl.clear) begin
			ab_found_q <= 1'b0;
			al_found_q <= 1'b0;
		end else begin
			if (take_ab) begin
				ab_found_q <= 1'b1;
			end
			if (take_al) begin
				al_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_ab) begin
			ab_idx_q  <= idx;
			ab_core_q <= core;
		end
		if (take_al) begin
			al_idx_q  <= idx;
			al_core_q <= core;
		end
	end

	assign found     = ab_found_q || al_found_q;
	assign pick_idx  = ab_found_q ? ab_idx_q : al_idx_q;
	assign pick_core = ab_found_q ? ab_core_q : al_core_q;

endmodule

`default_nettype wire

// File: rtl/core/core_spread_cpu_order_top.sv
// ----------------------------------------------------------------------------
// core_spread_cpu_order_top
// Loads a CPU-to-core table and emits the CPUs in core-spread order.
// ----------------------------------------------------------------------------
// Each input transaction stores one table entry. A transaction with tlast
// set starts the ordering run: every pick is one full pass of a single
// compare unit over the table RAM, one entry per cycle, and each pick
// waits in the pick state while the output is stalled. The input is not
// ready during a run. An output transaction is held in a register, so the
// next pass starts while it waits; m_tlast marks the last CPU of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module core_spread_cpu_order_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [5:0] cpu_slot, [11:6] core_number, zero pad
	input  wire logic        s_tlast,  // final_entry
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,  // [5:0] cpu_pick, zero pad
	output logic             m_tlast   // last_of_run
);

	csco_pkg::state_t                state_q;
	csco_pkg::state_t                state_d;
	logic [csco_pkg::CNT_W-1:0]      cnt_q;
	logic                            rd_valid_s1;
	logic [csco_pkg::ADDR_W-1:0]     addr_s1;
	logic                            first_q;
	logic [csco_pkg::CORE_W-1:0]     prev_q;
	logic [csco_pkg::MAX_CPUS-1:0]   mask_q;
	logic [csco_pkg::MAX_CPUS-1:0]   mask_load;
	logic [csco_pkg::MAX_CPUS-1:0]   mask_left;
	logic                            m_tvalid_q;
	logic [csco_pkg::SLOT_W-1:0]     pick_q;
	logic                            last_q;

	logic [csco_pkg::SLOT_W-1:0]     in_slot;
	logic [csco_pkg::CORE_W-1:0]     in_core;
	logic [csco_pkg::CORE_W-1:0]     core_sat;
	logic                            slot_ok;
	logic                            accept;
	logic                            issue;
	logic                            scan_done;
	logic                            out_free;
	logic                            load_out;
	logic                            pick_last;

	logic [csco_pkg::CORE_W-1:0]     rd_core;
	csco_pkg::scan_ctl_t             scan_ctl;
	logic                            pick_found;
	logic [csco_pkg::ADDR_W-1:0]     pick_idx;
	logic [csco_pkg::CORE_W-1:0]     pick_core;

	assign in_slot  = s_tdata[5:0];
	assign in_core  = s_tdata[11:6];
	assign core_sat = ({1'b0, in_core} >= 7'(csco_pkg::MAX_CORES)) ? csco_pkg::CORE_TOP
		: in_core;
	assign slot_ok  = {1'b0, in_slot} < 7'(csco_pkg::MAX_CPUS);
	assign accept   = s_tvalid && s_tready;
	assign scan_done = cnt_q == csco_pkg::CNT_W'(csco_pkg::MAX_CPUS);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		mask_load = mask_q;
		if (slot_ok) begin
			mask_load[in_slot[csco_pkg::ADDR_W-1:0]] = 1'b1;
		end
		mask_left = mask_q;
		mask_left[pick_idx] = 1'b0;
		pick_last = mask_left == '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			csco_pkg::ST_IDLE: begin
				if (accept && s_tlast && (mask_load != '0)) begin
					state_d = csco_pkg::ST_SCAN;
				end
			end
			csco_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = csco_pkg::ST_PICK;
				end
			end
			csco_pkg::ST_PICK: begin
				if (out_free) begin
					state_d = pick_last ? csco_pkg::ST_IDLE : csco_pkg::ST_SCAN;
				end
			end
			default: state_d = csco_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			csco_pkg::ST_IDLE: s_tready = 1'b1;
			csco_pkg::ST_SCAN: issue    = !scan_done;
			csco_pkg::ST_PICK: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csco_pkg::ST_IDLE;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			first_q     <= 1'b1;
			mask_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q != csco_pkg::ST_SCAN) begin
				cnt_q <= '0;
			end
			if (accept) begin
				mask_q  <= mask_load;
				first_q <= 1'b1;
			end
			if (load_out) begin
				mask_q  <= mask_left;
				first_q <= 1'b0;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= cnt_q[csco_pkg::ADDR_W-1:0];
		end
		if (load_out) begin
			prev_q <= pick_core;
			pick_q <= csco_pkg::SLOT_W'(pick_idx);
			last_q <= pick_last;
		end
	end

	csco_ram #(
		.WIDTH(csco_pkg::CORE_W),
		.DEPTH(csco_pkg::MAX_CPUS)
	) u_table (
		.clk    (clk),
		.wr_en  (accept && slot_ok),
		.wr_addr(in_slot[csco_pkg::ADDR_W-1:0]),
		.wr_data(core_sat),
		.rd_en  (issue),
		.rd_addr(cnt_q[csco_pkg::ADDR_W-1:0]),
		.rd_data(rd_core)
	);

	always_comb begin
		scan_ctl.clear   = (state_q == csco_pkg::ST_SCAN) && (cnt_q == '0);
		scan_ctl.valid   = rd_valid_s1;
		scan_ctl.present = mask_q[addr_s1];
		scan_ctl.first   = first_q;
	end

	csco_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.idx       (addr_s1),
		.core      (rd_core),
		.floor_core(prev_q),
		.found     (pick_found),
		.pick_idx  (pick_idx),
		.pick_core (pick_core)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, pick_q};
	assign m_tlast  = last_q;

	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == csco_pkg::ST_PICK |-> pick_found)
		else $error("no entry found at pick");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == csco_pkg::ST_SCAN |-> mask_q != '0)
		else $error("scan with empty table");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && pick_last |=> mask_q == '0 && state_q == csco_pkg::ST_IDLE)
		else $error("table not empty after run");

	a_out_from_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == csco_pkg::ST_PICK)
		else $error("output raised outside pick");

endmodule

`default_nettype wire
